// ===== hdl/bgi_pkg.sv =====
// Shared constants and types for the bilinear grid interpolator.
`default_nettype none
package bgi_pkg;

    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int POS_W  = 16;
    localparam int IPART_W = POS_W - FRAC_BITS;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int WROW_W = 8;
    localparam int WCOL_W = 8;
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int CFG_W  = 9;
    localparam int CFG_IDX_W = 1;

    // weights: one factor is 0..2^F, product of two is at most 2^(2F)
    localparam int FAC_W  = FRAC_BITS + 1;
    localparam int WT_W   = 2 * FRAC_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + WT_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHIFT  = 2 * FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RESET = 9'd256;
    localparam logic [CFG_W-1:0] ROWS_RESET = 9'd256;

    typedef struct packed {
        logic vld;
        logic first;
    } t_mac_ctl;

endpackage
`default_nettype wire

// ===== hdl/bgi_grid_ram.sv =====
// Single-port sample grid memory with registered read data.
`default_nettype none
module bgi_grid_ram (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [bgi_pkg::ADDR_W-1:0]      i_addr,
    input  wire logic [bgi_pkg::SAMPLE_BITS-1:0] i_wdata,
    output logic      [bgi_pkg::SAMPLE_BITS-1:0] o_rdata
);

    logic [bgi_pkg::SAMPLE_BITS-1:0] r_mem [bgi_pkg::MAX_ROWS * bgi_pkg::MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/bgi_mac.sv =====
// Weighted multiply-accumulate and round-to-nearest for one query.
`default_nettype none
module bgi_mac (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bgi_pkg::t_mac_ctl               i_ctl,
    input  wire logic [bgi_pkg::SAMPLE_BITS-1:0] i_rdata,
    input  wire logic [bgi_pkg::WT_W-1:0]        i_wt,
    output logic      [bgi_pkg::SAMPLE_BITS-1:0] o_value
);

    localparam int PROD_W = bgi_pkg::PROD_W;
    localparam int ACC_W  = bgi_pkg::ACC_W;

    logic                     r_p_vld;
    logic                     r_p_first;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_prod;
    logic        [ACC_W-1:0]  w_prod_ext;
    logic        [ACC_W-1:0]  w_rnd;

    assign w_prod     = PROD_W'($signed(i_rdata)) * PROD_W'($signed({1'b0, i_wt}));
    assign w_prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_p_first <= 1'b0;
        end else begin
            r_p_vld   <= i_ctl.vld;
            r_p_first <= i_ctl.first;
        end
        r_prod <= w_prod;
        if (r_p_vld) begin
            if (r_p_first) begin
                r_acc <= $signed(w_prod_ext);
            end else begin
                r_acc <= r_acc + $signed(w_prod_ext);
            end
        end
    end

    // add one half LSB of the result, then drop the fraction (floor)
    assign w_rnd   = r_acc + (ACC_W'(1) << (bgi_pkg::SHIFT - 1));
    assign o_value = w_rnd[bgi_pkg::SHIFT +: bgi_pkg::SAMPLE_BITS];

endmodule
`default_nettype wire

// ===== hdl/bilinear_grid_interpolator.sv =====
// Top level of the bilinear grid interpolator: sequencer, config and result register.
//   Input channel (i_in_valid / o_in_ready) carries one request: i_action = 0
//   stores i_write_value at (i_write_row, i_write_col); i_action = 1
//   interpolates at (i_x_pos, i_y_pos), unsigned with FRAC_BITS fraction bits.
//   Writes produce no result; each query produces one on the output channel
//   (o_out_valid / i_out_ready): o_value and o_out_of_range, the flag set with a
//   zero value when the ceiling column or row lies outside the ones in use.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   cols_in_use, index 1 sets rows_in_use; write only while idle.
// Sequence
//   A write goes straight to the RAM. An in-range query reads its four neighbors
//   from the single-port grid RAM, one per cycle, then drains the two-stage
//   multiply/accumulate; the result is then loaded into the output register
//   and the next request can be taken in the cycle after. An out-of-range query
//   skips the reads and the drain.
// Reset and stalls
//   Synchronous active-low reset clears control state and sets both in-use
//   registers to 256; grid contents are not cleared. A stalled receiver holds
//   the result in the output register; one more request is taken behind it
//   and waits there until the register drains.
`default_nettype none
module bilinear_grid_interpolator (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // config channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [bgi_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [bgi_pkg::CFG_W-1:0]              i_cfg_data,
    // request channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_action,
    input  wire logic [bgi_pkg::POS_W-1:0]              i_x_pos,
    input  wire logic [bgi_pkg::POS_W-1:0]              i_y_pos,
    input  wire logic [bgi_pkg::WROW_W-1:0]             i_write_row,
    input  wire logic [bgi_pkg::WCOL_W-1:0]             i_write_col,
    input  wire logic signed [bgi_pkg::SAMPLE_BITS-1:0] i_write_value,
    // result channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [bgi_pkg::SAMPLE_BITS-1:0]      o_value,
    output logic                                        o_out_of_range
);

    localparam int FB     = bgi_pkg::FRAC_BITS;
    localparam int IW     = bgi_pkg::IPART_W;
    localparam int COL_W  = bgi_pkg::COL_W;
    localparam int ROW_W  = bgi_pkg::ROW_W;
    localparam int ADDR_W = bgi_pkg::ADDR_W;
    localparam int FAC_W  = bgi_pkg::FAC_W;
    localparam int CMP_W  = 16;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [1:0] LAST_TAP  = 2'd3;
    localparam logic [1:0] DRAIN_END = 2'd1;

    // control
    logic [1:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd_vld;
    logic       r_rd_first;

    // configuration
    logic [bgi_pkg::CFG_W-1:0] r_cols;
    logic [bgi_pkg::CFG_W-1:0] r_rows;

    // latched query
    logic [COL_W-1:0] r_x1, r_x2;
    logic [ROW_W-1:0] r_y1, r_y2;
    logic [FB-1:0]    r_fx, r_fy;
    logic             r_oor;
    logic [bgi_pkg::WT_W-1:0] r_wt;

    // output register
    logic                             r_out_valid;
    logic [bgi_pkg::SAMPLE_BITS-1:0]  r_value;
    logic                             r_out_oor;

    // datapath
    logic             w_in_acc;
    logic [IW-1:0]    w_x1, w_y1;
    logic [FB-1:0]    w_fx, w_fy;
    logic [IW:0]      w_x2, w_y2;
    logic             w_oor;
    logic             w_wr_ok;
    logic             w_mem_we;
    logic [ADDR_W-1:0] w_wr_addr, w_rd_addr, w_addr;
    logic [COL_W-1:0] w_rd_col;
    logic [ROW_W-1:0] w_rd_row;
    logic [FAC_W-1:0] w_fa, w_fb;
    logic [2*FAC_W-1:0] w_wt_full;
    logic [bgi_pkg::SAMPLE_BITS-1:0] w_rdata;
    logic [bgi_pkg::SAMPLE_BITS-1:0] w_mac_value;
    logic             w_out_free;
    bgi_pkg::t_mac_ctl w_mac_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // coordinate split and range check on the incoming query
    assign w_x1 = i_x_pos[FB +: IW];
    assign w_y1 = i_y_pos[FB +: IW];
    assign w_fx = i_x_pos[FB-1:0];
    assign w_fy = i_y_pos[FB-1:0];
    assign w_x2 = {1'b0, w_x1} + (IW+1)'(w_fx != '0);
    assign w_y2 = {1'b0, w_y1} + (IW+1)'(w_fy != '0);
    assign w_oor = (CMP_W'(w_x2) >= CMP_W'(r_cols))
                || (CMP_W'(w_x2) >= CMP_W'(bgi_pkg::MAX_COLS))
                || (CMP_W'(w_y2) >= CMP_W'(r_rows))
                || (CMP_W'(w_y2) >= CMP_W'(bgi_pkg::MAX_ROWS));

    // sample writes go straight to the RAM while idle
    assign w_wr_ok  = (CMP_W'(i_write_row) < CMP_W'(bgi_pkg::MAX_ROWS))
                   && (CMP_W'(i_write_col) < CMP_W'(bgi_pkg::MAX_COLS));
    assign w_mem_we = w_in_acc && !i_action && w_wr_ok;
    assign w_wr_addr = ADDR_W'(i_write_row) * ADDR_W'(bgi_pkg::MAX_COLS)
                     + ADDR_W'(i_write_col);

    // neighbor select: bit 0 picks the ceiling column, bit 1 the ceiling row
    assign w_rd_col  = r_cnt[0] ? r_x2 : r_x1;
    assign w_rd_row  = r_cnt[1] ? r_y2 : r_y1;
    assign w_rd_addr = ADDR_W'(w_rd_row) * ADDR_W'(bgi_pkg::MAX_COLS) + ADDR_W'(w_rd_col);
    assign w_addr    = (r_state == S_IDLE) ? w_wr_addr : w_rd_addr;

    // weight of the neighbor being read: (F-f) for floor, f for ceiling
    assign w_fa = r_cnt[0] ? {1'b0, r_fx} : (FAC_W'(1) << FB) - {1'b0, r_fx};
    assign w_fb = r_cnt[1] ? {1'b0, r_fy} : (FAC_W'(1) << FB) - {1'b0, r_fy};
    assign w_wt_full = (2*FAC_W)'(w_fa) * (2*FAC_W)'(w_fb);

    assign w_mac_ctl.vld   = r_rd_vld;
    assign w_mac_ctl.first = r_rd_first;

    bgi_grid_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_addr),
        .i_wdata (i_write_value),
        .o_rdata (w_rdata)
    );

    bgi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_rdata (w_rdata),
        .i_wt    (r_wt),
        .o_value (w_mac_value)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_in_acc && i_action) begin
                    n_state = w_oor ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == LAST_TAP) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end
            end
            S_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == DRAIN_END) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_first  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cols      <= bgi_pkg::COLS_RESET;
            r_rows      <= bgi_pkg::ROWS_RESET;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_rd_vld   <= (r_state == S_READ);
            r_rd_first <= (r_state == S_READ) && (r_cnt == '0);

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bgi_pkg::REG_COLS: r_cols <= i_cfg_data;
                    bgi_pkg::REG_ROWS: r_rows <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload
        if (w_in_acc) begin
            r_x1  <= w_x1[COL_W-1:0];
            r_x2  <= w_x2[COL_W-1:0];
            r_y1  <= w_y1[ROW_W-1:0];
            r_y2  <= w_y2[ROW_W-1:0];
            r_fx  <= w_fx;
            r_fy  <= w_fy;
            r_oor <= w_oor;
        end
        r_wt <= w_wt_full[bgi_pkg::WT_W-1:0];
        if (r_state == S_DONE && w_out_free) begin
            r_value   <= r_oor ? '0 : w_mac_value;
            r_out_oor <= r_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_out_of_range = r_out_oor;

    // the RAM port is only written while the sequencer is idle
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> r_state == S_IDLE)
        else $error("grid write outside idle state");

    // an out-of-range result always carries a zero value
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> o_value == '0)
        else $error("out-of-range result with nonzero value");

    // exactly four taps are read before draining
    a_four_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == LAST_TAP) |=> r_state == S_DRAIN)
        else $error("read phase did not end after the fourth tap");

    // MAC input valid only follows a read cycle
    a_rd_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state) == S_READ)
        else $error("MAC fed without a preceding RAM read");

    // a result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> r_state == S_DONE)
        else $error("left done state while output register was blocked");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_grid_interpolator: directed table, then random traffic.
module tb;

    localparam int MAX_COLS    = bgi_pkg::MAX_COLS;
    localparam int MAX_ROWS    = bgi_pkg::MAX_ROWS;
    localparam int FRAC_BITS   = bgi_pkg::FRAC_BITS;
    localparam int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS;
    localparam int POS_W       = bgi_pkg::POS_W;
    localparam int IPART_W     = bgi_pkg::IPART_W;
    localparam int WROW_W      = bgi_pkg::WROW_W;
    localparam int WCOL_W      = bgi_pkg::WCOL_W;
    localparam int CFG_W       = bgi_pkg::CFG_W;
    localparam int CFG_IDX_W   = bgi_pkg::CFG_IDX_W;
    localparam int SHIFT       = bgi_pkg::SHIFT;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // query is loaded into the output register once its four neighbor reads and the MAC drain are done
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int FRAC_MAX        = (1 << FRAC_BITS) - 1;
    localparam int IPART_MAX       = (1 << IPART_W) - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          oor;
    } t_interp_result;

    // one row of the directed table; ev/eo are used only when typed is set
    typedef struct {
        logic                          act;
        logic [POS_W-1:0]              x;
        logic [POS_W-1:0]              y;
        logic [WROW_W-1:0]             wr;
        logic [WCOL_W-1:0]             wc;
        logic signed [SAMPLE_BITS-1:0] wv;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] ev;
        logic                          eo;
    } t_stim_row;

    // DUT ports
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index    = bgi_pkg::REG_COLS;
    logic [CFG_W-1:0]              i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic                          i_action       = ACT_WRITE;
    logic [POS_W-1:0]              i_x_pos        = '0;
    logic [POS_W-1:0]              i_y_pos        = '0;
    logic [WROW_W-1:0]             i_write_row    = '0;
    logic [WCOL_W-1:0]             i_write_col    = '0;
    logic signed [SAMPLE_BITS-1:0] i_write_value  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_value;
    logic                          o_out_of_range;

    // predictor state: grid contents, which cells hold data, in-use registers
    logic signed [SAMPLE_BITS-1:0] grid_model   [MAX_ROWS*MAX_COLS];
    bit                            grid_written [MAX_ROWS*MAX_COLS];
    logic [CFG_W-1:0]              cols_model = bgi_pkg::COLS_RESET;
    logic [CFG_W-1:0]              rows_model = bgi_pkg::ROWS_RESET;

    t_interp_result pending_results [$];

    int          err_count      = 0;
    int          items_accepted = 0;
    int          tx_burst       = 0;
    int          rx_burst       = 0;
    int          hold_off_len   = 0;
    int unsigned cycle_count    = 0;

    // Directed table. Cells (0..3, 0..1) and the far corner (254..255, 254..255)
    // are written first so every in-range query below reads written data.
    t_stim_row directed_rows [23] = '{
        // x/y fields set on a write: must be ignored
        '{ACT_WRITE, 16'hFFFF, 16'hFFFF,   0,   0,  32767, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   0,   1, -32768, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   1,   0, -32768, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   1,   1,  32767, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   2,   0,      1, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   2,   1,      0, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   3,   0,     -1, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000,   3,   1,      0, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000, 254, 254,  12345, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000, 254, 255, -20000, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000, 255, 254,    300, 0, 0, 0},
        '{ACT_WRITE, 16'h0000, 16'h0000, 255, 255,     -1, 0, 0, 0},
        // integer point returns the sample; write fields all ones are ignored
        '{ACT_QUERY, 16'h0000, 16'h0000, 255, 255,     -1, 1, 32767, 0},
        '{ACT_QUERY, 16'h0080, 16'h0000,   0,   0,      0, 0, 0, 0},
        '{ACT_QUERY, 16'h0080, 16'h0080,   0,   0,      0, 0, 0, 0},
        '{ACT_QUERY, 16'h00FF, 16'h00FF,   0,   0,      0, 0, 0, 0},
        // exact half between 1 and 0 rounds up, between -1 and 0 rounds to 0
        '{ACT_QUERY, 16'h0080, 16'h0200,   0,   0,      0, 1, 1, 0},
        '{ACT_QUERY, 16'h0080, 16'h0300,   0,   0,      0, 1, 0, 0},
        '{ACT_QUERY, 16'hFF00, 16'hFF00,   0,   0,      0, 1, -1, 0},
        '{ACT_QUERY, 16'hFF00, 16'hFE00,   0,   0,      0, 1, -20000, 0},
        '{ACT_QUERY, 16'hFE80, 16'hFE40,   0,   0,      0, 0, 0, 0},
        // ceiling column / row past the last one in use
        '{ACT_QUERY, 16'hFFFF, 16'h0000,   0,   0,      0, 1, 0, 1},
        '{ACT_QUERY, 16'h0000, 16'hFFFF,   0,   0,      0, 1, 0, 1}
    };

    bilinear_grid_interpolator uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    // idle cycles before the next request/ready; bursts give runs with no gaps
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(15, 0) == 0) begin
            burst = $urandom_range(30, 8);
            return 0;
        end
        return $urandom_range(11, 0);
    endfunction

    function automatic longint sample_at(int row, int col);
        return longint'(grid_model[row*MAX_COLS + col]);
    endfunction

    // bilinear sum of the four neighbors, round half up, or out of range
    function automatic t_interp_result interp_predict(logic [POS_W-1:0] x,
                                                      logic [POS_W-1:0] y);
        t_interp_result r;
        int     cols_eff, rows_eff, fx, fy, gx, gy, x1, y1, x2, y2;
        longint acc;
        cols_eff = (int'(cols_model) < MAX_COLS) ? int'(cols_model) : MAX_COLS;
        rows_eff = (int'(rows_model) < MAX_ROWS) ? int'(rows_model) : MAX_ROWS;
        fx = int'(x[FRAC_BITS-1:0]);
        fy = int'(y[FRAC_BITS-1:0]);
        x1 = int'(x[POS_W-1:FRAC_BITS]);
        y1 = int'(y[POS_W-1:FRAC_BITS]);
        x2 = x1 + ((fx != 0) ? 1 : 0);
        y2 = y1 + ((fy != 0) ? 1 : 0);
        r.value = '0;
        r.oor   = 1'b1;
        if (x2 < cols_eff && y2 < rows_eff) begin
            gx  = (1 << FRAC_BITS) - fx;
            gy  = (1 << FRAC_BITS) - fy;
            acc = sample_at(y1, x1) * longint'(gx * gy)
                + sample_at(y1, x2) * longint'(fx * gy)
                + sample_at(y2, x1) * longint'(gx * fy)
                + sample_at(y2, x2) * longint'(fx * fy);
            acc = acc + (longint'(1) <<< (SHIFT - 1));
            acc = acc >>> SHIFT;
            r.value = acc[SAMPLE_BITS-1:0];
            r.oor   = 1'b0;
        end
        return r;
    endfunction

    // Offer one request and hold it until taken; then update the predictor.
    // valid stays high straight into the next request when its gap is zero.
    task automatic send_request(logic act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [WROW_W-1:0] wr, logic [WCOL_W-1:0] wc,
                                logic signed [SAMPLE_BITS-1:0] wv, bit typed = 1'b0,
                                logic signed [SAMPLE_BITS-1:0] ev = '0,
                                logic eo = 1'b0);
        int             gap;
        int             slot;
        t_interp_result res;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_x_pos       <= x;
        i_y_pos       <= y;
        i_write_row   <= wr;
        i_write_col   <= wc;
        i_write_value <= wv;
        do @(posedge i_clk); while (!o_in_ready);
        items_accepted++;
        if (act == ACT_WRITE) begin
            if (int'(wr) < MAX_ROWS && int'(wc) < MAX_COLS) begin
                slot = int'(wr) * MAX_COLS + int'(wc);
                grid_model[slot]   = wv;
                grid_written[slot] = 1'b1;
            end
        end else begin
            if (typed) begin
                res.value = ev;
                res.oor   = eo;
            end else begin
                res = interp_predict(x, y);
            end
            pending_results.push_back(res);
        end
    endtask

    // stop offering, let every result come back, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid_size(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= bgi_pkg::REG_COLS;
        i_cfg_data  <= cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        cols_model = cols;
        i_cfg_index <= bgi_pkg::REG_ROWS;
        i_cfg_data  <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        rows_model = rows;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(7, 0))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return SAMPLE_BITS'(int'($urandom_range(2, 0)) - 1);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // coordinate whose ceiling stays below lim; "near" keeps to the grid edges
    // so cells get reused and fewer fill writes are needed
    function automatic logic [POS_W-1:0] coord_within(int lim, bit near);
        int ip, fr;
        if (near) begin
            ip = $urandom_range(((lim < 6) ? lim : 6) - 1, 0);
            if ($urandom_range(1, 0)) ip = lim - 1 - ip;
        end else begin
            ip = $urandom_range(lim - 1, 0);
        end
        case ($urandom_range(3, 0))
            0:       fr = 0;
            1:       fr = FRAC_MAX;
            default: fr = $urandom_range(FRAC_MAX, 0);
        endcase
        if (ip == lim - 1) fr = 0;
        return {ip[IPART_W-1:0], fr[FRAC_BITS-1:0]};
    endfunction

    // coordinate whose ceiling reaches lim or beyond
    function automatic logic [POS_W-1:0] coord_beyond(int lim);
        int ip, fr;
        if (lim <= 0) return POS_W'($urandom);
        ip = $urandom_range(IPART_MAX, lim - 1);
        fr = $urandom_range(FRAC_MAX, 0);
        if (ip == lim - 1 && fr == 0) fr = $urandom_range(FRAC_MAX, 1);
        return {ip[IPART_W-1:0], fr[FRAC_BITS-1:0]};
    endfunction

    // write any unwritten neighbor of (x, y), sometimes refresh a written one
    task automatic fill_neighbors(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        int xs[2];
        int ys[2];
        xs[0] = int'(x[POS_W-1:FRAC_BITS]);
        xs[1] = xs[0] + ((x[FRAC_BITS-1:0] != 0) ? 1 : 0);
        ys[0] = int'(y[POS_W-1:FRAC_BITS]);
        ys[1] = ys[0] + ((y[FRAC_BITS-1:0] != 0) ? 1 : 0);
        foreach (ys[r]) begin
            foreach (xs[c]) begin
                if (!grid_written[ys[r]*MAX_COLS + xs[c]] || $urandom_range(5, 0) == 0)
                    send_request(ACT_WRITE, POS_W'($urandom), POS_W'($urandom),
                                 WROW_W'(ys[r]), WCOL_W'(xs[c]), random_sample());
            end
        end
    endtask

    task automatic random_query(bit near);
        logic [POS_W-1:0] x, y;
        int               cols_eff, rows_eff;
        cols_eff = (int'(cols_model) < MAX_COLS) ? int'(cols_model) : MAX_COLS;
        rows_eff = (int'(rows_model) < MAX_ROWS) ? int'(rows_model) : MAX_ROWS;
        if ($urandom_range(4, 0) == 0 || cols_eff == 0 || rows_eff == 0) begin
            // out of range on one axis is enough; nothing is read
            if ($urandom_range(1, 0)) begin
                x = coord_beyond(cols_eff);
                y = POS_W'($urandom);
            end else begin
                x = POS_W'($urandom);
                y = coord_beyond(rows_eff);
            end
        end else begin
            x = coord_within(cols_eff, near);
            y = coord_within(rows_eff, near);
            fill_neighbors(x, y);
        end
        send_request(ACT_QUERY, x, y, WROW_W'($urandom), WCOL_W'($urandom),
                     SAMPLE_BITS'($urandom));
    endtask

    // mostly write-then-query sequences, some stray writes anywhere in the grid
    task automatic random_phase(int n_items);
        int stop_at;
        stop_at = items_accepted + n_items;
        while (items_accepted < stop_at) begin
            if ($urandom_range(9, 0) < 2)
                send_request(ACT_WRITE, POS_W'($urandom), POS_W'($urandom),
                             WROW_W'($urandom), WCOL_W'($urandom), random_sample());
            else
                random_query($urandom_range(1, 0));
        end
    endtask

    task automatic check_result();
        t_interp_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("result with no query pending: value %0d oor %0b",
                                    o_value, o_out_of_range));
        end else begin
            want = pending_results.pop_front();
            if (o_value !== want.value)
                flag_mismatch($sformatf("value %0d, predicted %0d", o_value, want.value));
            if (o_out_of_range !== want.oor)
                flag_mismatch($sformatf("out_of_range %0b, predicted %0b",
                                        o_out_of_range, want.oor));
        end
    endtask

    // result side: random ready gaps, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                gap          = hold_off_len;
                hold_off_len = 0;
            end else begin
                gap = draw_gap(rx_burst);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_result();
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the in-use registers: full grid
        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].x, directed_rows[i].y,
                         directed_rows[i].wr, directed_rows[i].wc, directed_rows[i].wv,
                         directed_rows[i].typed, directed_rows[i].ev, directed_rows[i].eo);
        random_phase(60);

        // sink stalls for a long stretch while requests keep coming back to back,
        // so the output register and the one-deep input slot fill and back up
        hold_off_len = HOLD_OFF_CYCLES;
        tx_burst     = 40;
        random_phase(40);

        // sender goes quiet until everything is back, then resumes
        drain_results();
        random_phase(40);

        // single cell: only the integer query at the origin is in range
        set_grid_size(1, 1);
        random_phase(30);
        // zero columns: every query out of range
        set_grid_size(0, 256);
        random_phase(25);
        // oversize value acts as the full grid; two rows
        set_grid_size(511, 2);
        random_phase(50);
        set_grid_size(37, 300);
        random_phase(60);
        set_grid_size(2, 257);
        random_phase(40);
        set_grid_size(256, 1);
        random_phase(40);

        drain_results();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bgi_pkg.sv
hdl/bgi_grid_ram.sv
hdl/bgi_mac.sv
hdl/bilinear_grid_interpolator.sv
test/tb.sv
